// File: rtl/slx_pkg.sv
// shared types, constants and byte classification for the script lexer
// no dependencies
`default_nettype none

package slx_pkg;

  // line counter width, counts saturate at all ones
  localparam int unsigned LineBits = 16;
  localparam int unsigned LineOutW = 16;

  // queue sizes
  localparam int unsigned CmdDepth = 2;
  localparam int unsigned CmdPtrW  = $clog2(CmdDepth);
  localparam int unsigned CmdCntW  = $clog2(CmdDepth + 1);
  localparam int unsigned ResDepth = 4;
  localparam int unsigned ResPtrW  = $clog2(ResDepth);
  localparam int unsigned ResCntW  = $clog2(ResDepth + 1);

  // token classes
  localparam logic [2:0] ClsIdent  = 3'd0;
  localparam logic [2:0] ClsNumber = 3'd1;
  localparam logic [2:0] ClsString = 3'd2;
  localparam logic [2:0] ClsSymbol = 3'd3;
  localparam logic [2:0] ClsEmpty  = 3'd4;

  // character codes
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChBang   = 8'h21;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChPct    = 8'h25;
  localparam logic [7:0] ChAmp    = 8'h26;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChLt     = 8'h3C;
  localparam logic [7:0] ChEq     = 8'h3D;
  localparam logic [7:0] ChGt     = 8'h3E;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpZ    = 8'h5A;
  localparam logic [7:0] ChLBrack = 8'h5B;
  localparam logic [7:0] ChRBrack = 8'h5D;
  localparam logic [7:0] ChCaret  = 8'h5E;
  localparam logic [7:0] ChUscore = 8'h5F;
  localparam logic [7:0] ChLoA    = 8'h61;
  localparam logic [7:0] ChLoZ    = 8'h7A;
  localparam logic [7:0] ChLBrace = 8'h7B;
  localparam logic [7:0] ChBar    = 8'h7C;
  localparam logic [7:0] ChRBrace = 8'h7D;
  localparam logic [7:0] CaseBit  = 8'h20;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last_in;
  } item_t;

  typedef struct packed {
    logic [7:0]          char_out;
    logic [2:0]          token_class;
    logic                token_start;
    logic                token_end;
    logic [LineOutW-1:0] line_number;
    logic                run_last;
  } res_t;

  typedef struct packed {
    logic upper;
    logic letter;
    logic digit;
    logic ws;
    logic symbol;
    logic quote;
    logic nl;
    logic dot;
    logic star;
    logic slash;
    logic eq;
  } char_info_t;

  // one queued unit of work: the held byte with its lookahead, and/or the final byte
  typedef struct packed {
    logic       has_a;
    logic [7:0] a_char;
    char_info_t a_info;
    logic       a_pair;
    logic       has_b;
    logic [7:0] c_char;
    char_info_t c_info;
  } cmd_t;

  // results handed from the back end to the result queue in one cycle
  typedef struct packed {
    logic [1:0] n;
    res_t       d0;
    res_t       d1;
  } res_push_t;

  typedef enum logic [10:0] {
    ModeIdle   = 11'h001,
    ModeIdent  = 11'h002,
    ModeNum    = 11'h004,
    ModeStr    = 11'h008,
    ModeSym2   = 11'h010,
    ModeEqDrop = 11'h020,
    ModeCOpen  = 11'h040,
    ModeCBody  = 11'h080,
    ModeCClose = 11'h100,
    ModeLOpen  = 11'h200,
    ModeLine   = 11'h400
  } mode_e;

  function automatic char_info_t char_info(logic [7:0] c);
    char_info_t ci;
    ci.upper  = (c >= ChUpA) && (c <= ChUpZ);
    ci.letter = ci.upper || ((c >= ChLoA) && (c <= ChLoZ)) || (c == ChUscore);
    ci.digit  = (c >= ChZero) && (c <= ChNine);
    ci.ws     = (c == ChSpace) || (c == ChTab) || (c == ChCr) || (c == ChLf);
    ci.symbol = (c == ChLParen) || (c == ChRParen) || (c == ChLBrack) ||
                (c == ChRBrack) || (c == ChLBrace) || (c == ChRBrace) ||
                (c == ChSemi)   || (c == ChEq)     || (c == ChPlus)   ||
                (c == ChMinus)  || (c == ChStar)   || (c == ChSlash)  ||
                (c == ChComma)  || (c == ChBang)   || (c == ChAmp)    ||
                (c == ChBar)    || (c == ChCaret)  || (c == ChPct)    ||
                (c == ChLt)     || (c == ChGt);
    ci.quote  = (c == ChQuote);
    ci.nl     = (c == ChLf);
    ci.dot    = (c == ChDot);
    ci.star   = (c == ChStar);
    ci.slash  = (c == ChSlash);
    ci.eq     = (c == ChEq);
    return ci;
  endfunction

  // two-byte symbol test
  function automatic logic is_pair(logic [7:0] c, logic [7:0] p);
    logic eq_pair;
    logic dbl_pair;
    eq_pair  = ((c == ChPlus) || (c == ChMinus) || (c == ChStar) || (c == ChSlash) ||
                (c == ChLt) || (c == ChGt) || (c == ChBang)) && (p == ChEq);
    dbl_pair = ((c == ChPlus) || (c == ChMinus) || (c == ChAmp) || (c == ChBar) ||
                (c == ChCaret)) && (p == c);
    return eq_pair || dbl_pair || ((c == ChStar) && (p == ChSlash));
  endfunction

endpackage

`default_nettype wire

// File: rtl/script_lexer.sv
// script lexer top level: streaming tokenizer with one byte of lookahead
// a byte's result reaches the result ports through the work queue and then the result
//   queue, both registered, after the beat that brings its lookahead byte (or its own
//   beat when it is marked final); a result queue without room holds it in the work queue
// throughput: one source byte per cycle while the work queue is not full; results leave
//   one per cycle, and a final beat can yield two results
// reset: asynchronous, clears the held byte, the lexer state, line count and both queues
// depends on slx_pkg, slx_front, slx_cmd_queue, slx_back, slx_res_queue
`default_nettype none

module script_lexer import slx_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  // source side
  input  wire logic  push,
  output logic       full,
  input  wire item_t item_i,
  // result side
  output logic       empty,
  input  wire logic  pop,
  output res_t       result_o
);

  // front to work queue
  logic      cmd_push;
  cmd_t      cmd_in;
  logic      cmd_full;
  // work queue to back end
  logic      cmd_valid;
  logic      cmd_pop;
  cmd_t      cmd_out;
  // back end to result queue
  res_push_t res_push;
  logic      res_room;

  // the source side stalls only when the work queue is full
  assign full = cmd_full;

  // front end: holds the lookahead byte and classifies each byte pair;
  // a beat that completes no byte (first byte of a text) queues nothing
  slx_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .item_i     (item_i),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  // two-entry queue decouples the front from the back
  slx_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .cmd_o   (cmd_out)
  );

  // back end: runs the lexer modes; takes work only while the result
  // queue can take two results, which is the most one beat can make
  slx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .res_room_i  (res_room),
    .cmd_pop_o   (cmd_pop),
    .res_push_o  (res_push)
  );

  // result queue: oldest result sits on result_o while empty is low
  slx_res_queue u_res_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .room_o (res_room),
    .pop    (pop),
    .empty  (empty),
    .res_o  (result_o)
  );

endmodule

`default_nettype wire

// File: rtl/slx_front.sv
// front end: takes source bytes, holds one back as lookahead, classifies
// depends on slx_pkg
`default_nettype none

module slx_front import slx_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push,
  input  wire item_t item_i,
  input  wire logic  cmd_full_i,
  output logic       cmd_push_o,
  output cmd_t       cmd_o
);

  logic [7:0] held_char_q, held_char_d;
  logic       held_valid_q, held_valid_d;
  logic       accept;
  char_info_t c_info;

  assign accept = push && !cmd_full_i;
  assign c_info = char_info(item_i.char_in);

  always_comb begin
    held_char_d  = held_char_q;
    held_valid_d = held_valid_q;
    if (accept) begin
      // final byte flushes the lookahead
      if (item_i.last_in) begin
        held_char_d  = '0;
        held_valid_d = 1'b0;
      end else begin
        held_char_d  = item_i.char_in;
        held_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_char_q  <= '0;
      held_valid_q <= 1'b0;
    end else begin
      held_char_q  <= held_char_d;
      held_valid_q <= held_valid_d;
    end
  end

  assign cmd_push_o    = accept && (held_valid_q || item_i.last_in);
  assign cmd_o.has_a   = held_valid_q;
  assign cmd_o.a_char  = held_char_q;
  assign cmd_o.a_info  = char_info(held_char_q);
  assign cmd_o.a_pair  = is_pair(held_char_q, item_i.char_in);
  assign cmd_o.has_b   = item_i.last_in;
  assign cmd_o.c_char  = item_i.char_in;
  assign cmd_o.c_info  = c_info;

endmodule

`default_nettype wire

// File: rtl/slx_cmd_queue.sv
// short queue of classified work between the front and back ends
// depends on slx_pkg
`default_nettype none

module slx_cmd_queue import slx_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output cmd_t      cmd_o
);

  cmd_t               mem_q [CmdDepth];
  logic [CmdPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CmdCntW-1:0] cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CmdCntW'(CmdDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + CmdCntW'(do_push) - CmdCntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/slx_back.sv
// back end: lexer state machine, runs the held byte and the final byte of one beat
// depends on slx_pkg
`default_nettype none

module slx_back import slx_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  input  wire cmd_t cmd_i,
  input  wire logic res_room_i,
  output logic      cmd_pop_o,
  output res_push_t res_push_o
);

  typedef struct packed {
    mode_e               mode;
    logic                dot;
    logic [LineBits-1:0] line;
    logic                emit;
    res_t                res;
  } step_t;

  mode_e               mode_q, mode_d;
  logic                dot_q, dot_d;
  logic [LineBits-1:0] line_q, line_d;
  step_t               sa, sb;
  mode_e               mode_b;
  logic                dot_b;
  logic [LineBits-1:0] line_b;
  logic                ea, eb;
  res_t                ra, rb;

  function automatic logic [7:0] lower(logic [7:0] c, char_info_t ci);
    return ci.upper ? (c | CaseBit) : c;
  endfunction

  function automatic step_t lex_step(mode_e mode, logic dot, logic [LineBits-1:0] line,
                                     logic [7:0] c, char_info_t ci, logic pv,
                                     char_info_t pi, logic pair);
    step_t s;
    logic  cont;
    logic  d;
    s.mode = mode;
    s.dot  = dot;
    s.line = line;
    s.emit = 1'b0;
    s.res.char_out    = c;
    s.res.token_class = ClsEmpty;
    s.res.token_start = 1'b0;
    s.res.token_end   = 1'b0;
    s.res.line_number = LineOutW'(line);
    s.res.run_last    = 1'b0;
    cont = 1'b0;
    d    = dot;
    case (mode)
      ModeIdle: begin
        if (ci.ws) begin
          s.emit = 1'b0;
        end else if (ci.letter) begin
          cont = pv && (pi.letter || pi.digit || pi.dot);
          s.emit = 1'b1;
          s.res.char_out    = lower(c, ci);
          s.res.token_class = ClsIdent;
          s.res.token_start = 1'b1;
          s.res.token_end   = !cont;
          s.mode = cont ? ModeIdent : ModeIdle;
        end else if (ci.digit) begin
          s.dot = 1'b0;
          cont = pv && (pi.digit || pi.dot);
          s.emit = 1'b1;
          s.res.token_class = ClsNumber;
          s.res.token_start = 1'b1;
          s.res.token_end   = !cont;
          s.mode = cont ? ModeNum : ModeIdle;
        end else if (ci.quote) begin
          s.emit = 1'b1;
          s.res.token_class = ClsString;
          s.res.token_start = 1'b1;
          s.res.token_end   = !pv;
          s.mode = pv ? ModeStr : ModeIdle;
        end else if (ci.symbol) begin
          s.res.token_class = ClsSymbol;
          s.res.token_start = 1'b1;
          if (pv && ci.slash && pi.star) begin
            s.mode = ModeCOpen;
          end else if (pv && ci.slash && pi.slash) begin
            s.mode = ModeLOpen;
          end else if (pv && ci.eq && pi.eq) begin
            s.emit = 1'b1;
            s.res.token_end = 1'b1;
            s.mode = ModeEqDrop;
          end else if (pv && pair) begin
            s.emit = 1'b1;
            s.mode = ModeSym2;
          end else begin
            s.emit = 1'b1;
            s.res.token_end = 1'b1;
          end
        end else begin
          s.emit = 1'b1;
          s.res.char_out    = '0;
          s.res.token_start = 1'b1;
          s.res.token_end   = 1'b1;
        end
      end
      ModeIdent: begin
        cont = pv && (pi.letter || pi.digit || pi.dot);
        s.emit = 1'b1;
        s.res.char_out    = lower(c, ci);
        s.res.token_class = ClsIdent;
        s.res.token_end   = !cont;
        if (!cont) begin
          s.mode = ModeIdle;
        end
      end
      ModeNum: begin
        d = dot || ci.dot;
        s.dot = d;
        cont = pv && (pi.digit || (pi.dot && !d));
        s.emit = 1'b1;
        s.res.token_class = ClsNumber;
        s.res.token_end   = !cont;
        if (!cont) begin
          s.mode = ModeIdle;
        end
      end
      ModeStr: begin
        cont = pv && !ci.quote && !ci.nl;
        s.emit = 1'b1;
        s.res.token_class = ClsString;
        s.res.token_end   = !cont;
        if (!cont) begin
          s.mode = ModeIdle;
        end
      end
      ModeSym2: begin
        s.emit = 1'b1;
        s.res.token_class = ClsSymbol;
        s.res.token_end   = 1'b1;
        s.mode = ModeIdle;
      end
      ModeCOpen: begin
        s.mode = ModeCBody;
      end
      ModeCBody: begin
        if (ci.star && pv && pi.slash) begin
          s.mode = ModeCClose;
        end
      end
      ModeLOpen: begin
        s.mode = ModeLine;
      end
      ModeLine: begin
        if (ci.nl) begin
          s.mode = ModeIdle;
        end
      end
      default: begin
        // closing slash of a comment, or second '=' of ==
        s.mode = ModeIdle;
      end
    endcase
    if (ci.nl && (line != '1)) begin
      s.line = line + 1'b1;
    end
    return s;
  endfunction

  assign cmd_pop_o = cmd_valid_i && res_room_i;

  always_comb begin
    sa = lex_step(mode_q, dot_q, line_q, cmd_i.a_char, cmd_i.a_info, 1'b1,
                  cmd_i.c_info, cmd_i.a_pair);
    mode_b = cmd_i.has_a ? sa.mode : mode_q;
    dot_b  = cmd_i.has_a ? sa.dot  : dot_q;
    line_b = cmd_i.has_a ? sa.line : line_q;
    sb = lex_step(mode_b, dot_b, line_b, cmd_i.c_char, cmd_i.c_info, 1'b0,
                  '0, 1'b0);
    ea = cmd_i.has_a && sa.emit;
    eb = cmd_i.has_b && sb.emit;
    ra = sa.res;
    rb = sb.res;
    if (eb) begin
      rb.run_last = 1'b1;
    end else begin
      ra.run_last = 1'b1;
    end
    res_push_o.n  = cmd_pop_o ? (2'(ea) + 2'(eb)) : 2'd0;
    res_push_o.d0 = ea ? ra : rb;
    res_push_o.d1 = rb;

    mode_d = mode_q;
    dot_d  = dot_q;
    line_d = line_q;
    if (cmd_pop_o) begin
      if (cmd_i.has_b) begin
        // end of text, back to reset
        mode_d = ModeIdle;
        dot_d  = 1'b0;
        line_d = '0;
      end else begin
        mode_d = sa.mode;
        dot_d  = sa.dot;
        line_d = sa.line;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      dot_q  <= 1'b0;
      line_q <= '0;
    end else begin
      mode_q <= mode_d;
      dot_q  <= dot_d;
      line_q <= line_d;
    end
  end

  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop_o && cmd_i.has_b) |=> (mode_q == ModeIdle && line_q == '0 && !dot_q))
    else $error("state not cleared after final byte");

  a_push_needs_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o.n != 2'd0) |-> cmd_pop_o)
    else $error("result pushed without work taken");

  a_two_needs_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o.n == 2'd2) |-> (cmd_i.has_a && cmd_i.has_b))
    else $error("two results from a single consumed byte");

endmodule

`default_nettype wire

// File: rtl/slx_res_queue.sv
// result queue: takes up to two results a cycle, hands out one
// depends on slx_pkg
`default_nettype none

module slx_res_queue import slx_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire res_push_t push_i,
  output logic           room_o,
  input  wire logic      pop,
  output logic           empty,
  output res_t           res_o
);

  res_t               mem_q [ResDepth];
  logic [ResPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [ResCntW-1:0] cnt_q, cnt_d;
  logic               do_pop;

  assign empty  = (cnt_q == '0);
  assign room_o = (cnt_q <= ResCntW'(ResDepth - 2));
  assign res_o  = mem_q[rd_q];
  assign do_pop = pop && !empty;

  always_comb begin
    wr_d  = wr_q + ResPtrW'(push_i.n);
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + ResCntW'(push_i.n) - ResCntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_q] <= push_i.d0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_q + 1'b1] <= push_i.d1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ResCntW'(ResDepth))
    else $error("result queue overflow");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.n != 2'd0) |=> !empty)
    else $error("pushed result not visible");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.n != 2'd0) |-> room_o)
    else $error("push into a queue without room");

endmodule

`default_nettype wire
